FILE: rtl/fully_assoc_lru_cache_macros.svh
// ----------------------------------------------------------------------------
// fully associative lru cache assertion macros
// shared concurrent assertion forms for the cache rtl
// ----------------------------------------------------------------------------
`ifndef FULLY_ASSOC_LRU_CACHE_MACROS_SVH
`define FULLY_ASSOC_LRU_CACHE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FALC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("falc assertion failed");

// next-cycle implication, disabled while in reset
`define FALC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("falc assertion failed");

`endif

FILE: rtl/falc_pkg.sv
// ----------------------------------------------------------------------------
// falc_pkg
// sizes, derived widths and controller states of the fully associative cache
// ----------------------------------------------------------------------------
package falc_pkg;

  // geometry (line size is a power of two)
  localparam int LINE_BYTES = 64;
  localparam int NUM_LINES  = 16;
  localparam int ADDR_BITS  = 32;

  // address split
  localparam int ADDR_IN_W = 32;
  localparam int ADDR_W    = (ADDR_BITS < ADDR_IN_W) ? ADDR_BITS : ADDR_IN_W;
  localparam int OFF_W     = $clog2(LINE_BYTES);
  localparam int TAG_W     = ADDR_W - OFF_W;

  // line index and victim tree
  localparam int IDX_W  = $clog2(NUM_LINES);
  localparam int LEAF_N = 1 << IDX_W;
  localparam int FOLD_W = $clog2(IDX_W + 1);
  localparam int FILL_W = $clog2(NUM_LINES + 1);

  // ages
  localparam int              AGE_W   = 32;
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // data store
  localparam int DATA_W     = 8;
  localparam int DATA_DEPTH = NUM_LINES * LINE_BYTES;
  localparam int DADDR_W    = IDX_W + OFF_W;

  // stream payloads
  localparam int IN_TDATA_W  = 40;
  localparam int LINE_USED_W = 4;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - DATA_W - LINE_USED_W;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SEARCH,
    ST_READ,
    ST_COMMIT
  } falc_state_t;

endpackage

FILE: rtl/falc_ram.sv
// ----------------------------------------------------------------------------
// falc_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module falc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fully_assoc_lru_cache.sv
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache
// fully associative byte cache with age-counter lru replacement
// ----------------------------------------------------------------------------
//  channel   dir  tdata                               tuser
//  s_axis    in   address[31:0], write_data[39:32]    req_type (1 = write)
//  m_axis    out  hit[0], read_data[8:1],             -
//                 line_used[12:9], zero[15:13]
//
//  one request at a time: accept, tag lookup, ram read and commit for
//  a hit or a fill of a free line; a miss with all lines in use adds
//  a search through the registered max-age tree before the ram read.
//  byte data and a per-line written-byte map sit in two rams with registered read data;
//  a fill clears only the map word, so no clearing pass is needed.
//  rst is synchronous; valid bits, ages and fill count clear at once.
//  a result waiting on m_tready holds the commit step; the next beat is
//  taken once the controller is back in idle.
// ----------------------------------------------------------------------------
`include "fully_assoc_lru_cache_macros.svh"

module fully_assoc_lru_cache (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [falc_pkg::IN_TDATA_W-1:0]  s_tdata,   // address, write_data
  input  logic                             s_tuser,   // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [falc_pkg::OUT_TDATA_W-1:0] m_tdata    // hit, read_data, line_used, pad
);

  falc_pkg::falc_state_t state, state_next;

  // request registers
  logic                             req_write;
  logic [falc_pkg::TAG_W-1:0]       req_tag;
  logic [falc_pkg::OFF_W-1:0]       req_off;
  logic [falc_pkg::DATA_W-1:0]      req_wdata;

  // line directory
  logic                             line_valid [falc_pkg::NUM_LINES];
  logic [falc_pkg::TAG_W-1:0]       line_tag   [falc_pkg::NUM_LINES];
  logic [falc_pkg::AGE_W-1:0]       line_age   [falc_pkg::NUM_LINES];
  logic [falc_pkg::FILL_W-1:0]      lines_filled;
  logic                             full;

  // lookup result
  logic                             match_any;
  logic [falc_pkg::IDX_W-1:0]       match_idx;
  logic                             hit_r;
  logic [falc_pkg::IDX_W-1:0]       pos;

  // victim tree
  logic [falc_pkg::AGE_W-1:0]       cand_age      [falc_pkg::LEAF_N];
  logic [falc_pkg::IDX_W-1:0]       cand_idx      [falc_pkg::LEAF_N];
  logic [falc_pkg::AGE_W-1:0]       fold_src_age  [falc_pkg::LEAF_N];
  logic [falc_pkg::IDX_W-1:0]       fold_src_idx  [falc_pkg::LEAF_N];
  logic [falc_pkg::AGE_W-1:0]       fold_age      [falc_pkg::LEAF_N];
  logic [falc_pkg::IDX_W-1:0]       fold_idx      [falc_pkg::LEAF_N];
  logic [falc_pkg::FOLD_W-1:0]      fold_cnt;
  logic                             search_done;

  // ram ports
  logic                             ram_re;
  logic [falc_pkg::DADDR_W-1:0]     data_addr;
  logic                             data_we;
  logic [falc_pkg::DATA_W-1:0]      data_rd;
  logic                             map_we;
  logic [falc_pkg::LINE_BYTES-1:0]  map_rd;
  logic [falc_pkg::LINE_BYTES-1:0]  map_wr;
  logic [falc_pkg::LINE_BYTES-1:0]  off_bit;

  // output register
  logic                             out_valid;
  logic                             out_hit;
  logic [falc_pkg::DATA_W-1:0]      out_rdata;
  logic [falc_pkg::LINE_USED_W-1:0] out_line;
  logic                             out_free;
  logic                             commit_go;
  logic [falc_pkg::DATA_W-1:0]      rd_byte;

  assign full     = (lines_filled == falc_pkg::FILL_W'(falc_pkg::NUM_LINES));
  assign out_free = !out_valid || m_tready;

  // tag match against every valid line
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = falc_pkg::NUM_LINES - 1; i >= 0; i--) begin
      if (line_valid[i] && (line_tag[i] == req_tag)) begin
        match_any = 1'b1;
        match_idx = falc_pkg::IDX_W'(i);
      end
    end
  end

  // one level of the max-age tree, left wins ties
  always_comb begin
    for (int i = 0; i < falc_pkg::LEAF_N; i++) begin
      if (state == falc_pkg::ST_LOOKUP) begin
        fold_src_age[i] = (i < falc_pkg::NUM_LINES) ? line_age[i] : '0;
        fold_src_idx[i] = falc_pkg::IDX_W'(i);
      end else begin
        fold_src_age[i] = cand_age[i];
        fold_src_idx[i] = cand_idx[i];
      end
    end
    for (int i = 0; i < falc_pkg::LEAF_N; i++) begin
      fold_age[i] = fold_src_age[i];
      fold_idx[i] = fold_src_idx[i];
    end
    for (int i = 0; i < falc_pkg::LEAF_N / 2; i++) begin
      if (fold_src_age[2*i+1] > fold_src_age[2*i]) begin
        fold_age[i] = fold_src_age[2*i+1];
        fold_idx[i] = fold_src_idx[2*i+1];
      end else begin
        fold_age[i] = fold_src_age[2*i];
        fold_idx[i] = fold_src_idx[2*i];
      end
    end
  end

  assign search_done = (fold_cnt == falc_pkg::FOLD_W'(falc_pkg::IDX_W));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      falc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = falc_pkg::ST_LOOKUP;
        end
      end
      falc_pkg::ST_LOOKUP: begin
        state_next = (!match_any && full) ? falc_pkg::ST_SEARCH : falc_pkg::ST_READ;
      end
      falc_pkg::ST_SEARCH: begin
        if (search_done) begin
          state_next = falc_pkg::ST_READ;
        end
      end
      falc_pkg::ST_READ: begin
        state_next = falc_pkg::ST_COMMIT;
      end
      falc_pkg::ST_COMMIT: begin
        if (out_free) begin
          state_next = falc_pkg::ST_IDLE;
        end
      end
      default: state_next = falc_pkg::ST_IDLE;
    endcase
  end

  // controller outputs, no beat is taken while in reset
  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    commit_go = 1'b0;
    unique case (state)
      falc_pkg::ST_IDLE:   s_tready  = !rst;
      falc_pkg::ST_READ:   ram_re    = 1'b1;
      falc_pkg::ST_COMMIT: commit_go = out_free;
      falc_pkg::ST_LOOKUP, falc_pkg::ST_SEARCH: begin
        s_tready = 1'b0;
      end
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= falc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture request beat
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_write <= s_tuser;
      req_tag   <= s_tdata[falc_pkg::ADDR_W-1:falc_pkg::OFF_W];
      req_off   <= s_tdata[falc_pkg::OFF_W-1:0];
      req_wdata <= s_tdata[falc_pkg::ADDR_IN_W +: falc_pkg::DATA_W];
    end
  end

  // line choice and victim tree registers
  always_ff @(posedge clk) begin
    if (state == falc_pkg::ST_LOOKUP) begin
      hit_r    <= match_any;
      fold_cnt <= falc_pkg::FOLD_W'(1);
      if (match_any) begin
        pos <= match_idx;
      end else if (!full) begin
        pos <= falc_pkg::IDX_W'(lines_filled);
      end
    end else if (state == falc_pkg::ST_SEARCH) begin
      if (search_done) begin
        pos <= cand_idx[0];
      end else begin
        fold_cnt <= fold_cnt + falc_pkg::FOLD_W'(1);
      end
    end
    if ((state == falc_pkg::ST_LOOKUP) ||
        ((state == falc_pkg::ST_SEARCH) && !search_done)) begin
      for (int i = 0; i < falc_pkg::LEAF_N; i++) begin
        cand_age[i] <= fold_age[i];
        cand_idx[i] <= fold_idx[i];
      end
    end
  end

  // data and written-byte map rams
  assign data_addr = {pos, req_off};
  assign off_bit   = falc_pkg::LINE_BYTES'(1) << req_off;
  assign data_we   = commit_go && req_write;
  assign map_we    = commit_go && (req_write || !hit_r);
  assign map_wr    = (hit_r ? map_rd : '0) | (req_write ? off_bit : '0);

  falc_ram #(
    .WIDTH (falc_pkg::DATA_W),
    .DEPTH (falc_pkg::DATA_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_addr),
    .wdata (req_wdata),
    .re    (ram_re),
    .raddr (data_addr),
    .rdata (data_rd)
  );

  falc_ram #(
    .WIDTH (falc_pkg::LINE_BYTES),
    .DEPTH (falc_pkg::NUM_LINES)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (pos),
    .wdata (map_wr),
    .re    (ram_re),
    .raddr (pos),
    .rdata (map_rd)
  );

  // bytes never written since the fill read as zero
  assign rd_byte = (!req_write && hit_r && map_rd[req_off]) ? data_rd : '0;

  // directory update at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      lines_filled <= '0;
      for (int i = 0; i < falc_pkg::NUM_LINES; i++) begin
        line_valid[i] <= 1'b0;
        line_age[i]   <= '0;
      end
    end else if (commit_go) begin
      if (!hit_r && !full) begin
        lines_filled <= lines_filled + falc_pkg::FILL_W'(1);
      end
      for (int i = 0; i < falc_pkg::NUM_LINES; i++) begin
        if (pos == falc_pkg::IDX_W'(i)) begin
          line_valid[i] <= 1'b1;
          line_age[i]   <= '0;
        end else if (line_valid[i] && (line_age[i] != falc_pkg::AGE_MAX)) begin
          line_age[i] <= line_age[i] + falc_pkg::AGE_W'(1);
        end
      end
    end
  end

  // tags carry no reset
  always_ff @(posedge clk) begin
    if (commit_go && !hit_r) begin
      line_tag[pos] <= req_tag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_hit   <= hit_r;
      out_rdata <= rd_byte;
      out_line  <= falc_pkg::LINE_USED_W'(pos);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{falc_pkg::OUT_PAD_W{1'b0}}, out_line, out_rdata, out_hit};

  // checks
  `FALC_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, lines_filled <= falc_pkg::FILL_W'(falc_pkg::NUM_LINES))
  `FALC_ASSERT_IMPL(a_hit_tag, clk, rst, (state == falc_pkg::ST_COMMIT) && hit_r, line_valid[pos] && (line_tag[pos] == req_tag))
  `FALC_ASSERT_IMPL(a_search_full, clk, rst, state == falc_pkg::ST_SEARCH, full)
  `FALC_ASSERT_NEXT(a_used_young, clk, rst, commit_go, line_valid[pos] && (line_age[pos] == '0))

endmodule

FILE: tb/sv/fully_assoc_lru_cache_test.sv
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_test
// Stream-level test of the fully associative LRU byte cache. A scoreboard
// keeps its own copy of line tags, bytes, ages and the fill count. From each
// accepted request beat it works out the hit flag, the read byte and the line
// used, and checks each result beat against the oldest prediction. The
// stimulus starts with directed cases: address extremes, a write miss, read
// hits, fill to capacity and eviction. Random requests follow, drawn mostly
// from a small tag pool so that hits and evictions both happen often. Both
// sides idle at random, and twice the result side holds off long enough to
// back up the input.
// ----------------------------------------------------------------------------
module fully_assoc_lru_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 450;
  localparam int PHASE_ITEMS  = 75;
  localparam int POOL_DEPTH   = 32;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;

  localparam bit REQ_READ  = 1'b0;
  localparam bit REQ_WRITE = 1'b1;

  typedef struct packed {
    logic                             hit;
    logic [falc_pkg::DATA_W-1:0]      read_data;
    logic [falc_pkg::LINE_USED_W-1:0] line_used;
  } cache_result_t;

  // cache scoreboard: tracks line state and holds predicted results in order
  class lru_cache_scoreboard;
    bit                         line_valid [falc_pkg::NUM_LINES];
    bit [falc_pkg::TAG_W-1:0]   line_tag   [falc_pkg::NUM_LINES];
    bit [falc_pkg::DATA_W-1:0]  line_data  [falc_pkg::NUM_LINES][falc_pkg::LINE_BYTES];
    bit [falc_pkg::AGE_W-1:0]   line_age   [falc_pkg::NUM_LINES];
    int unsigned                lines_filled;
    cache_result_t              predicted_results [$];
    int unsigned                mismatches;

    function cache_result_t predict_access(bit is_write, bit [31:0] addr,
                                           bit [7:0] wdata);
      bit [falc_pkg::TAG_W-1:0] tag;
      int unsigned              offset;
      int unsigned              pos;
      bit                       found;
      cache_result_t            res;
      tag    = addr[falc_pkg::ADDR_W-1:falc_pkg::OFF_W];
      offset = 32'(addr[falc_pkg::OFF_W-1:0]);
      found  = 1'b0;
      pos    = 0;
      res    = '0;

      // tag match, lowest matching line
      for (int i = 0; i < falc_pkg::NUM_LINES; i++) begin
        if (!found && line_valid[i] && line_tag[i] == tag) begin
          found = 1'b1;
          pos   = i;
        end
      end

      // miss: next unused line, else oldest with lowest index on a tie
      if (!found) begin
        if (lines_filled < falc_pkg::NUM_LINES) begin
          pos = lines_filled;
          lines_filled++;
        end else begin
          for (int i = 1; i < falc_pkg::NUM_LINES; i++)
            if (line_age[i] > line_age[pos]) pos = i;
        end
        for (int b = 0; b < falc_pkg::LINE_BYTES; b++) line_data[pos][b] = '0;
        line_valid[pos] = 1'b1;
        line_tag[pos]   = tag;
      end

      if (is_write) line_data[pos][offset] = wdata;
      else res.read_data = line_data[pos][offset];

      // age update, saturating
      line_age[pos] = '0;
      for (int i = 0; i < falc_pkg::NUM_LINES; i++) begin
        if (i != pos && line_valid[i] && line_age[i] != falc_pkg::AGE_MAX)
          line_age[i]++;
      end

      res.hit       = found;
      res.line_used = pos[falc_pkg::LINE_USED_W-1:0];
      return res;
    endfunction

    function void note_request(bit is_write, bit [31:0] addr, bit [7:0] wdata);
      cache_result_t res;
      res = predict_access(is_write, addr, wdata);
      predicted_results.insert(predicted_results.size(), res);
    endfunction

    function void check_result(logic [falc_pkg::OUT_TDATA_W-1:0] beat);
      cache_result_t exp_res;
      cache_result_t got;
      got.hit       = beat[0];
      got.read_data = beat[8:1];
      got.line_used = beat[12:9];
      if (predicted_results.size() == 0) begin
        $display("%0t: result beat %h with nothing expected", $time, beat);
        mismatches++;
        return;
      end
      exp_res = predicted_results.pop_front();
      if (got.hit !== exp_res.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, exp_res.hit, got.hit);
        mismatches++;
      end
      if (got.read_data !== exp_res.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time,
                 exp_res.read_data, got.read_data);
        mismatches++;
      end
      if (got.line_used !== exp_res.line_used) begin
        $display("%0t: line_used expected %0d actual %0d", $time,
                 exp_res.line_used, got.line_used);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return predicted_results.size();
    endfunction
  endclass

  logic                             clk      = 1'b0;
  logic                             rst      = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [falc_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                             s_tuser  = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [falc_pkg::OUT_TDATA_W-1:0] m_tdata;

  lru_cache_scoreboard       cache_sb = new();
  bit                        idle_on = 1'b1;
  bit                        hold_request = 1'b0;
  int unsigned               quiet_cycles = 0;
  bit [falc_pkg::TAG_W-1:0]  tag_pool [POOL_DEPTH];

  always #1 clk = ~clk;

  fully_assoc_lru_cache dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // offer one request beat after a random gap, return after acceptance
  task automatic send_request(bit is_write, bit [31:0] addr, bit [7:0] wdata);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {wdata, addr};
    s_tuser  <= is_write;
    do @(posedge clk); while (!s_tready);
    cache_sb.note_request(is_write, addr, wdata);
    @(negedge clk);
  endtask

  // random request: mostly pooled tags, sometimes a fully random address
  task automatic send_random_request(int unsigned pool_size);
    bit [31:0] addr;
    addr = $urandom();
    if ($urandom_range(0, 99) < 85)
      addr[falc_pkg::ADDR_W-1:falc_pkg::OFF_W] = tag_pool[$urandom_range(0, pool_size - 1)];
    send_request(1'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)));
  endtask

  // result side: random ready gaps, long hold-off on request
  initial begin
    int unsigned gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      cache_sb.check_result(m_tdata);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // reset, directed cases, random phases, drain and verdict
  initial begin
    int unsigned pool_size;
    for (int i = 0; i < POOL_DEPTH; i++) tag_pool[i] = falc_pkg::TAG_W'($urandom());
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // write miss, read hits, address extremes, last offset in a line
    send_request(REQ_WRITE, 32'h0000_0000, 8'hFF);
    send_request(REQ_READ,  32'h0000_0000, 8'h00);
    send_request(REQ_READ,  32'hFFFF_FFFF, 8'hFF);
    send_request(REQ_WRITE, 32'hFFFF_FFFF, 8'h00);
    send_request(REQ_WRITE, 32'h0000_003F, 8'hA5);
    send_request(REQ_READ,  32'h0000_003F, 8'h00);
    send_request(REQ_READ,  32'h0000_0040, 8'h00);
    send_request(REQ_WRITE, 32'h8000_0000, 8'h5A);
    // fill every remaining line
    for (int k = 0; k < 12; k++)
      send_request(REQ_WRITE, 32'(32'h0001_0000 * (k + 1) + k), 8'(8'h10 + k));
    // evictions once all lines are in use
    send_request(REQ_READ,  32'h1234_5678, 8'h00);
    send_request(REQ_READ,  32'hFFFF_FFC0, 8'h00);
    send_request(REQ_READ,  32'h0000_0000, 8'h00);
    send_request(REQ_WRITE, 32'h0000_0001, 8'h3C);

    // random phases with varying tag pool size and idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        idle_on   = ((n / PHASE_ITEMS) % 3) != 2;
        pool_size = (n / PHASE_ITEMS) % 2 ? 12 : 24 + $urandom_range(0, 8);
      end
      if (n == 120 || n == 330) hold_request = 1'b1;
      send_random_request(pool_size);
    end
    s_tvalid <= 1'b0;

    while (cache_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cache_sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/falc_pkg.sv
rtl/falc_ram.sv
rtl/fully_assoc_lru_cache.sv
tb/sv/fully_assoc_lru_cache_test.sv
